@@ rtl/core/pstd_pkg.sv @@
// pstd_pkg: shared types, register map and constants for the pose to step delta core
// no dependencies; used by pstd_regs, pstd_trig and pose_to_step_delta_core
package pstd_pkg;

  // configuration register map (byte address = 4 * index)
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_TOOL_TIP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SCALE_X    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCALE_Y    = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCALE_Z    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALE_TILT = 3'd4;
  localparam logic [IDX_W-1:0] REG_SCALE_SPIN = 3'd5;

  // register reset values
  localparam logic [31:0] TOOL_TIP_RST = 32'd0;
  localparam logic [31:0] SCALE_RST    = 32'd65536;

  // q30 constants for the sine table build
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // one input item
  typedef struct packed {
    logic signed [31:0] x_mm;
    logic signed [31:0] y_mm;
    logic signed [31:0] z_mm;
    logic signed [23:0] tilt_turns;
    logic signed [23:0] spin_turns;
    logic signed [31:0] cur_x_steps;
    logic signed [31:0] cur_y_steps;
    logic signed [31:0] cur_z_steps;
    logic signed [31:0] cur_tilt_steps;
    logic signed [31:0] cur_spin_steps;
  } in_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] dx_steps;
    logic signed [31:0] dy_steps;
    logic signed [31:0] dz_steps;
    logic signed [31:0] dtilt_steps;
    logic signed [31:0] dspin_steps;
    logic               saturated;
  } out_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic signed [31:0] tool_tip;
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
    logic [31:0]        scale_z;
    logic [31:0]        scale_tilt;
    logic [31:0]        scale_spin;
  } cfg_t;

  // sin or cos of th (q30 radians, 0 to pi/2) by taylor series, clamped to [0, 1.0]
  // only evaluated on constants while the table is built
  function automatic logic [63:0] taylor_q30(input logic [63:0] th, input logic want_cos);
    logic [63:0] th2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      ss;
    longint      cc;
    th2 = (th * th) >> 30;
    ts  = th;
    tc  = Q30_ONE;
    ss  = longint'(th);
    cc  = longint'(Q30_ONE);
    for (int n = 2; n <= 16; n += 2) begin
      tc = ((tc * th2) >> 30) / 64'((n - 1) * n);
      ts = ((ts * th2) >> 30) / 64'(n * (n + 1));
      if ((n & 2) != 0) begin
        cc = cc - longint'(tc);
        ss = ss - longint'(ts);
      end else begin
        cc = cc + longint'(tc);
        ss = ss + longint'(ts);
      end
    end
    if (ss < 0) ss = 0;
    if (ss > longint'(Q30_ONE)) ss = longint'(Q30_ONE);
    if (cc < 0) cc = 0;
    if (cc > longint'(Q30_ONE)) cc = longint'(Q30_ONE);
    return want_cos ? 64'(cc) : 64'(ss);
  endfunction

endpackage

@@ rtl/core/pstd_regs.sv @@
// pstd_regs: apb configuration registers (tip offset and five step scales)
// depends on pstd_pkg for the register map, reset values and cfg_t
module pstd_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pstd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output pstd_pkg::cfg_t                cfg_o
);

  pstd_pkg::cfg_t                cfg_d, cfg_q;
  logic [pstd_pkg::IDX_W-1:0]    idx;
  logic                          wr_en;

  assign idx    = paddr[pstd_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // write decode, unknown index ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        pstd_pkg::REG_TOOL_TIP:   cfg_d.tool_tip   = signed'(pwdata);
        pstd_pkg::REG_SCALE_X:    cfg_d.scale_x    = pwdata;
        pstd_pkg::REG_SCALE_Y:    cfg_d.scale_y    = pwdata;
        pstd_pkg::REG_SCALE_Z:    cfg_d.scale_z    = pwdata;
        pstd_pkg::REG_SCALE_TILT: cfg_d.scale_tilt = pwdata;
        pstd_pkg::REG_SCALE_SPIN: cfg_d.scale_spin = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tool_tip   <= signed'(pstd_pkg::TOOL_TIP_RST);
      cfg_q.scale_x    <= pstd_pkg::SCALE_RST;
      cfg_q.scale_y    <= pstd_pkg::SCALE_RST;
      cfg_q.scale_z    <= pstd_pkg::SCALE_RST;
      cfg_q.scale_tilt <= pstd_pkg::SCALE_RST;
      cfg_q.scale_spin <= pstd_pkg::SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      pstd_pkg::REG_TOOL_TIP:   prdata = cfg_q.tool_tip;
      pstd_pkg::REG_SCALE_X:    prdata = cfg_q.scale_x;
      pstd_pkg::REG_SCALE_Y:    prdata = cfg_q.scale_y;
      pstd_pkg::REG_SCALE_Z:    prdata = cfg_q.scale_z;
      pstd_pkg::REG_SCALE_TILT: prdata = cfg_q.scale_tilt;
      pstd_pkg::REG_SCALE_SPIN: prdata = cfg_q.scale_spin;
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/pstd_trig.sv @@
// pstd_trig: two-stage sine and cosine lookup of an angle in turns
// depends on pstd_pkg for the taylor function that builds the quarter-wave table
module pstd_trig #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned FRAC_BITS          = 16
) (
  input  logic                        clk_i,
  input  logic [23:0]                 angle_i,
  output logic signed [FRAC_BITS+1:0] sin_o,
  output logic signed [FRAC_BITS+1:0] cos_o
);

  localparam int unsigned KW      = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned IW      = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned PM_W    = FRAC_BITS + KW;
  localparam int unsigned QW      = IW + 2;
  localparam int unsigned TAB_DIV = (SINE_TABLE_ENTRIES % 4 == 0) ? 4 : 1;
  localparam int unsigned TAB_N   = SINE_TABLE_ENTRIES / TAB_DIV;
  localparam int unsigned TIW     = $clog2(TAB_N);
  localparam int unsigned TV_W    = FRAC_BITS + 1;
  localparam int unsigned SW      = FRAC_BITS + 2;
  localparam logic [63:0] TAB_RND = 64'd1 << (29 - FRAC_BITS);

  // quarter-wave table, one entry per distinct in-quadrant step
  logic [TV_W-1:0] sin_tab [TAB_N];
  logic [TV_W-1:0] cos_tab [TAB_N];

  for (genvar j = 0; j < TAB_N; j++) begin : g_tab
    localparam logic [63:0] THETA =
      (pstd_pkg::HALF_PI_Q30 * 64'(j * TAB_DIV)) / SINE_TABLE_ENTRIES;
    localparam logic [63:0] SIN_Q = pstd_pkg::taylor_q30(THETA, 1'b0);
    localparam logic [63:0] COS_Q = pstd_pkg::taylor_q30(THETA, 1'b1);
    assign sin_tab[j] = TV_W'((SIN_Q + TAB_RND) >> (30 - FRAC_BITS));
    assign cos_tab[j] = TV_W'((COS_Q + TAB_RND) >> (30 - FRAC_BITS));
  end

  // stage a: round phase to a table step, split into quadrant and offset
  logic [PM_W-1:0] pm;
  logic [KW-1:0]   k_full;
  logic [IW-1:0]   k;
  logic [QW-1:0]   k4;
  logic [QW-1:0]   r;
  logic [1:0]      quad_d, quad_q;
  logic [TIW-1:0]  ti_d, ti_q;

  always_comb begin
    pm = PM_W'(angle_i[FRAC_BITS-1:0]) * PM_W'(SINE_TABLE_ENTRIES)
       + PM_W'(2 ** (FRAC_BITS - 1));
    k_full = pm[PM_W-1:FRAC_BITS];
    k  = (k_full >= KW'(SINE_TABLE_ENTRIES)) ? '0 : k_full[IW-1:0];
    k4 = {k, 2'b00};
    priority if (k4 >= QW'(3 * SINE_TABLE_ENTRIES)) begin
      quad_d = 2'd3;
      r      = k4 - QW'(3 * SINE_TABLE_ENTRIES);
    end else if (k4 >= QW'(2 * SINE_TABLE_ENTRIES)) begin
      quad_d = 2'd2;
      r      = k4 - QW'(2 * SINE_TABLE_ENTRIES);
    end else if (k4 >= QW'(SINE_TABLE_ENTRIES)) begin
      quad_d = 2'd1;
      r      = k4 - QW'(SINE_TABLE_ENTRIES);
    end else begin
      quad_d = 2'd0;
      r      = k4;
    end
    ti_d = TIW'(r / TAB_DIV);
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    ti_q   <= ti_d;
  end

  // stage b: table read and quadrant fold
  logic signed [SW-1:0] s_w, c_w;
  logic signed [SW-1:0] sin_d, cos_d;

  always_comb begin
    s_w = signed'({1'b0, sin_tab[ti_q]});
    c_w = signed'({1'b0, cos_tab[ti_q]});
    unique case (quad_q)
      2'd0: begin sin_d = s_w;  cos_d = c_w;  end
      2'd1: begin sin_d = c_w;  cos_d = -s_w; end
      2'd2: begin sin_d = -s_w; cos_d = -c_w; end
      default: begin sin_d = -c_w; cos_d = s_w; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sin_o <= sin_d;
    cos_o <= cos_d;
  end

endmodule

@@ rtl/core/pstd_rotate.sv @@
// pstd_rotate: two-stage frame transform (rotation by spin, tip offset, sign flips)
// no package dependency; results leave as magnitude and sign with 2*FRAC_BITS fraction bits
module pstd_rotate #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic signed [31:0]                     x_i,
  input  logic signed [31:0]                     y_i,
  input  logic signed [31:0]                     z_i,
  input  logic signed [23:0]                     tilt_i,
  input  logic signed [23:0]                     spin_i,
  input  logic signed [FRAC_BITS+1:0]            sy_i,
  input  logic signed [FRAC_BITS+1:0]            cy_i,
  input  logic signed [FRAC_BITS+1:0]            sz_i,
  input  logic signed [FRAC_BITS+1:0]            cz_i,
  input  logic signed [31:0]                     tip_i,
  output logic [4:0][FRAC_BITS+33:0]             mag_o,
  output logic [4:0]                             neg_o
);

  localparam int unsigned SW   = FRAC_BITS + 2;
  localparam int unsigned OMW  = SW + 1;
  localparam int unsigned PRW  = 32 + SW;
  localparam int unsigned PW   = FRAC_BITS + 35;
  localparam int unsigned MAGW = PW - 1;

  // stage c: products
  logic signed [OMW-1:0] one_w, sy_w, oms;
  logic signed [PRW-1:0] xs_q, yc_q, xc_q, ys_q, tc_q;
  logic signed [PW-1:0]  tsy_q;
  logic signed [31:0]    z_q;
  logic signed [23:0]    tilt_q, spin_q;

  assign one_w = OMW'(2 ** FRAC_BITS);
  assign sy_w  = OMW'(sy_i);
  assign oms   = one_w - sy_w;

  always_ff @(posedge clk_i) begin
    xs_q   <= x_i * sz_i;
    yc_q   <= y_i * cz_i;
    xc_q   <= x_i * cz_i;
    ys_q   <= y_i * sz_i;
    tc_q   <= tip_i * cy_i;
    tsy_q  <= tip_i * oms;
    z_q    <= z_i;
    tilt_q <= tilt_i;
    spin_q <= spin_i;
  end

  // stage d: sums, then split into magnitude and sign
  logic signed [PW-1:0]    p [5];
  logic [4:0][MAGW-1:0]    mag_d;
  logic [4:0]              neg_d;

  always_comb begin
    p[0] = PW'(yc_q) - PW'(xs_q);
    p[1] = PW'(xc_q) + PW'(ys_q) + PW'(tc_q);
    p[2] = tsy_q - (PW'(z_q) <<< FRAC_BITS);
    p[3] = PW'(tilt_q) <<< FRAC_BITS;
    p[4] = -(PW'(spin_q) <<< FRAC_BITS);
    for (int i = 0; i < 5; i++) begin
      neg_d[i] = p[i][PW-1];
      mag_d[i] = neg_d[i] ? MAGW'(-p[i]) : MAGW'(p[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_o <= mag_d;
    neg_o <= neg_d;
  end

endmodule

@@ rtl/core/pstd_step.sv @@
// pstd_step: three-stage step conversion of one axis (scale, truncate, delta, saturate)
// no package dependency; the magnitude-by-scale product is split in two partial products
module pstd_step #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic [FRAC_BITS+33:0]      mag_i,
  input  logic                       neg_i,
  input  logic [31:0]                scale_i,
  input  logic signed [31:0]         cur_i,
  output logic signed [31:0]         delta_o,
  output logic                       sat_o
);

  localparam int unsigned MAGW = FRAC_BITS + 34;
  localparam int unsigned HW   = MAGW - 32;
  localparam int unsigned PRW  = MAGW + 32;
  localparam int unsigned TW   = PRW - 3 * FRAC_BITS;
  localparam int unsigned CW   = (TW > 33) ? TW : 33;

  // stage e: partial products
  logic [63:0]        plo_q;
  logic [HW+31:0]     phi_q;
  logic               neg_e_q;
  logic signed [31:0] cur_e_q;

  always_ff @(posedge clk_i) begin
    plo_q   <= 64'(mag_i[31:0]) * 64'(scale_i);
    phi_q   <= (HW + 32)'(mag_i[MAGW-1:32]) * (HW + 32)'(scale_i);
    neg_e_q <= neg_i;
    cur_e_q <= cur_i;
  end

  // stage f: combine, drop fraction bits, clip the target magnitude
  logic [PRW-1:0]     prod;
  logic [CW-1:0]      t_ext;
  logic [CW-1:0]      lim;
  logic               tsat;
  logic [31:0]        t_d, t_q;
  logic               neg_f_q, tsat_q;
  logic signed [31:0] cur_f_q;

  always_comb begin
    prod  = (PRW'(phi_q) << 32) + PRW'(plo_q);
    t_ext = CW'(prod[PRW-1:3*FRAC_BITS]);
    lim   = neg_e_q ? CW'(33'h0_8000_0000) : CW'(33'h0_7fff_ffff);
    tsat  = t_ext > lim;
    t_d   = tsat ? lim[31:0] : t_ext[31:0];
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    neg_f_q <= neg_e_q;
    tsat_q  <= tsat;
    cur_f_q <= cur_e_q;
  end

  // stage g: subtract current position and clip to 32 bits
  logic signed [33:0] tgt, diff;
  logic               dsat;
  logic signed [31:0] delta_d;

  always_comb begin
    tgt  = signed'({2'b00, t_q});
    if (neg_f_q) tgt = -tgt;
    diff = tgt - 34'(cur_f_q);
    dsat = (diff[33:31] != 3'b000) && (diff[33:31] != 3'b111);
    if (dsat) begin
      delta_d = diff[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      delta_d = diff[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    delta_o <= delta_d;
    sat_o   <= tsat_q | dsat;
  end

endmodule

@@ rtl/core/pose_to_step_delta_core.sv @@
// pose_to_step_delta_core: five-axis pose to motor step delta, fully pipelined
// one item per cycle, busy is never raised
// stages: angle step, sine table, products, sums, partial products, truncate, delta
// the receiver cannot stall; each result shows for one cycle with done_o
// reset clears the valid pipeline and loads the register reset values
// depends on pstd_pkg, pstd_regs, pstd_trig, pstd_rotate and pstd_step
module pose_to_step_delta_core #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned FRAC_BITS          = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  pstd_pkg::in_t                 in_i,
  output logic                          done_o,
  output pstd_pkg::out_t                result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pstd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned LAT  = 7;
  localparam int unsigned SW   = FRAC_BITS + 2;
  localparam int unsigned MAGW = FRAC_BITS + 34;

  pstd_pkg::cfg_t cfg;

  // configuration registers
  pstd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // valid bits ride along with the item
  logic [LAT-1:0] vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start & ~busy};
    end
  end

  // trig stages for both angles
  logic signed [SW-1:0] sy, cy, sz, cz;

  pstd_trig #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .FRAC_BITS          (FRAC_BITS)
  ) u_trig_tilt (
    .clk_i   (clk_i),
    .angle_i (in_i.tilt_turns),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  pstd_trig #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .FRAC_BITS          (FRAC_BITS)
  ) u_trig_spin (
    .clk_i   (clk_i),
    .angle_i (in_i.spin_turns),
    .sin_o   (sz),
    .cos_o   (cz)
  );

  // item payload alongside the trig stages
  pstd_pkg::in_t pay_a_q, pay_b_q;

  always_ff @(posedge clk_i) begin
    pay_a_q <= in_i;
    pay_b_q <= pay_a_q;
  end

  // frame transform
  logic [4:0][MAGW-1:0] mag;
  logic [4:0]           neg;

  pstd_rotate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotate (
    .clk_i  (clk_i),
    .x_i    (pay_b_q.x_mm),
    .y_i    (pay_b_q.y_mm),
    .z_i    (pay_b_q.z_mm),
    .tilt_i (pay_b_q.tilt_turns),
    .spin_i (pay_b_q.spin_turns),
    .sy_i   (sy),
    .cy_i   (cy),
    .sz_i   (sz),
    .cz_i   (cz),
    .tip_i  (cfg.tool_tip),
    .mag_o  (mag),
    .neg_o  (neg)
  );

  // current step counts alongside the transform stages
  logic [4:0][31:0] curs_b;
  logic [4:0][31:0] curs_c_q, curs_d_q;

  assign curs_b[0] = pay_b_q.cur_x_steps;
  assign curs_b[1] = pay_b_q.cur_y_steps;
  assign curs_b[2] = pay_b_q.cur_z_steps;
  assign curs_b[3] = pay_b_q.cur_tilt_steps;
  assign curs_b[4] = pay_b_q.cur_spin_steps;

  always_ff @(posedge clk_i) begin
    curs_c_q <= curs_b;
    curs_d_q <= curs_c_q;
  end

  // per-axis step conversion
  logic [4:0][31:0] scales;
  logic [4:0][31:0] deltas;
  logic [4:0]       sats;

  assign scales[0] = cfg.scale_x;
  assign scales[1] = cfg.scale_y;
  assign scales[2] = cfg.scale_z;
  assign scales[3] = cfg.scale_tilt;
  assign scales[4] = cfg.scale_spin;

  for (genvar i = 0; i < 5; i++) begin : g_axis
    pstd_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk_i   (clk_i),
      .mag_i   (mag[i]),
      .neg_i   (neg[i]),
      .scale_i (scales[i]),
      .cur_i   (signed'(curs_d_q[i])),
      .delta_o (deltas[i]),
      .sat_o   (sats[i])
    );
  end

  // result item
  assign done_o               = vld_q[LAT-1];
  assign result_o.dx_steps    = signed'(deltas[0]);
  assign result_o.dy_steps    = signed'(deltas[1]);
  assign result_o.dz_steps    = signed'(deltas[2]);
  assign result_o.dtilt_steps = signed'(deltas[3]);
  assign result_o.dspin_steps = signed'(deltas[4]);
  assign result_o.saturated   = |sats;

endmodule

@@ verif/pose_to_step_delta_checker.sv @@
// pose_to_step_delta_checker: predicts the step deltas of every accepted pose and
// compares them with the results of the core; tracks register writes and checks reads
// depends on pstd_pkg for the item, result and register types
module pose_to_step_delta_checker #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned FRAC_BITS          = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  pstd_pkg::in_t               item_i,
  input  logic                        done_i,
  input  pstd_pkg::out_t              result_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [pstd_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic [31:0]                 prdata_i,
  input  logic                        pready_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o,
  output int unsigned                 clipped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned word64_t;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int unsigned PRINT_CAP = 20;

  pstd_pkg::cfg_t regs;
  pstd_pkg::out_t expected_q[$];
  int unsigned    errors  = 0;
  int unsigned    pending = 0;
  int unsigned    checked = 0;
  int unsigned    clipped = 0;

  assign errors_o  = errors;
  assign pending_o = pending;
  assign checked_o = checked;
  assign clipped_o = clipped;

  // sine and cosine over the first quadrant, q30 in and out, clamped to [0, 1.0]
  function automatic void quarter_wave_q30(input word64_t th, output word64_t s_out,
                                           output word64_t c_out);
    word64_t th2;
    word64_t ts;
    word64_t tc;
    longint  s_acc;
    longint  c_acc;
    th2   = (th * th) >> 30;
    ts    = th;
    tc    = pstd_pkg::Q30_ONE;
    s_acc = longint'(th);
    c_acc = longint'(pstd_pkg::Q30_ONE);
    for (int unsigned n = 2; n <= 16; n += 2) begin
      tc = ((tc * th2) >> 30) / word64_t'((n - 1) * n);
      ts = ((ts * th2) >> 30) / word64_t'(n * (n + 1));
      if (((n / 2) % 2) == 1) begin
        c_acc = c_acc - longint'(tc);
        s_acc = s_acc - longint'(ts);
      end else begin
        c_acc = c_acc + longint'(tc);
        s_acc = s_acc + longint'(ts);
      end
    end
    if (s_acc < 0) s_acc = 0;
    if (s_acc > longint'(pstd_pkg::Q30_ONE)) s_acc = longint'(pstd_pkg::Q30_ONE);
    if (c_acc < 0) c_acc = 0;
    if (c_acc > longint'(pstd_pkg::Q30_ONE)) c_acc = longint'(pstd_pkg::Q30_ONE);
    s_out = word64_t'(s_acc);
    c_out = word64_t'(c_acc);
  endfunction

  // angle in turns -> nearest table step -> quadrant fold -> signed sin and cos
  function automatic void angle_sin_cos(input logic [23:0] ang, output longint sn,
                                        output longint cs);
    word64_t phase;
    word64_t k;
    word64_t quad;
    word64_t rem;
    word64_t s;
    word64_t c;
    phase = word64_t'(ang) & ((word64_t'(1) << FRAC_BITS) - 1);
    k = (phase * SINE_TABLE_ENTRIES + (word64_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (k >= SINE_TABLE_ENTRIES) k = 0;
    quad = (4 * k) / SINE_TABLE_ENTRIES;
    rem  = 4 * k - quad * SINE_TABLE_ENTRIES;
    quarter_wave_q30((pstd_pkg::HALF_PI_Q30 * rem) / SINE_TABLE_ENTRIES, s, c);
    s = (s + (word64_t'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    c = (c + (word64_t'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    case (quad % 4)
      0: begin
        sn = longint'(s);
        cs = longint'(c);
      end
      1: begin
        sn = longint'(c);
        cs = -longint'(s);
      end
      2: begin
        sn = -longint'(s);
        cs = -longint'(c);
      end
      default: begin
        sn = -longint'(c);
        cs = longint'(s);
      end
    endcase
  endfunction

  // exact printer-frame value times scale, truncated toward zero, clipped to 32 bits
  function automatic longint scale_to_steps(input longint pos, input logic [31:0] scale,
                                            inout bit clip);
    bit          neg;
    logic [63:0] mag;
    logic [95:0] prod;
    logic [95:0] whole;
    longint      lim;
    neg   = pos < 0;
    mag   = neg ? -pos : pos;
    prod  = {32'b0, mag} * {64'b0, scale};
    whole = prod >> (3 * FRAC_BITS);
    lim   = neg ? -S32_MIN : S32_MAX;
    if (whole > 96'(lim)) begin
      clip  = 1'b1;
      whole = 96'(lim);
    end
    return neg ? -longint'(whole[63:0]) : longint'(whole[63:0]);
  endfunction

  // expected step deltas for one pose under the current registers
  function automatic pstd_pkg::out_t predict_delta(input pstd_pkg::in_t v);
    longint         x, y, z, tilt, spin, tip, one;
    longint         tilt_sin, tilt_cos, spin_sin, spin_cos;
    longint         pos[5];
    longint         cur[5];
    longint         delta[5];
    logic [31:0]    scale[5];
    bit             clip;
    pstd_pkg::out_t r;
    x    = $signed(v.x_mm);
    y    = $signed(v.y_mm);
    z    = $signed(v.z_mm);
    tilt = $signed(v.tilt_turns);
    spin = $signed(v.spin_turns);
    tip  = $signed(regs.tool_tip);
    one  = longint'(1) << FRAC_BITS;
    angle_sin_cos(v.tilt_turns, tilt_sin, tilt_cos);
    angle_sin_cos(v.spin_turns, spin_sin, spin_cos);
    // rotate about z, add the tip offset, flip z and spin
    pos[0] = -(x * spin_sin) + y * spin_cos;
    pos[1] = x * spin_cos + y * spin_sin + tip * tilt_cos;
    pos[2] = -(z * one) + tip * (one - tilt_sin);
    pos[3] = tilt * one;
    pos[4] = -(spin * one);
    scale = '{regs.scale_x, regs.scale_y, regs.scale_z, regs.scale_tilt, regs.scale_spin};
    cur[0] = $signed(v.cur_x_steps);
    cur[1] = $signed(v.cur_y_steps);
    cur[2] = $signed(v.cur_z_steps);
    cur[3] = $signed(v.cur_tilt_steps);
    cur[4] = $signed(v.cur_spin_steps);
    clip = 1'b0;
    for (int a = 0; a < 5; a++) begin
      delta[a] = scale_to_steps(pos[a], scale[a], clip) - cur[a];
      if (delta[a] > S32_MAX) begin
        delta[a] = S32_MAX;
        clip     = 1'b1;
      end
      if (delta[a] < S32_MIN) begin
        delta[a] = S32_MIN;
        clip     = 1'b1;
      end
    end
    r.dx_steps    = 32'(delta[0]);
    r.dy_steps    = 32'(delta[1]);
    r.dz_steps    = 32'(delta[2]);
    r.dtilt_steps = 32'(delta[3]);
    r.dspin_steps = 32'(delta[4]);
    r.saturated   = clip;
    return r;
  endfunction

  // register value by index; unknown indexes hold nothing
  function automatic bit register_value(input logic [pstd_pkg::IDX_W-1:0] idx,
                                        output logic [31:0] val);
    val = '0;
    case (idx)
      pstd_pkg::REG_TOOL_TIP:   val = regs.tool_tip;
      pstd_pkg::REG_SCALE_X:    val = regs.scale_x;
      pstd_pkg::REG_SCALE_Y:    val = regs.scale_y;
      pstd_pkg::REG_SCALE_Z:    val = regs.scale_z;
      pstd_pkg::REG_SCALE_TILT: val = regs.scale_tilt;
      pstd_pkg::REG_SCALE_SPIN: val = regs.scale_spin;
      default:                  return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    logic [pstd_pkg::IDX_W-1:0] idx;
    logic [31:0]                reg_val;
    pstd_pkg::out_t             want;
    if (!rst_ni) begin
      regs.tool_tip   = pstd_pkg::TOOL_TIP_RST;
      regs.scale_x    = pstd_pkg::SCALE_RST;
      regs.scale_y    = pstd_pkg::SCALE_RST;
      regs.scale_z    = pstd_pkg::SCALE_RST;
      regs.scale_tilt = pstd_pkg::SCALE_RST;
      regs.scale_spin = pstd_pkg::SCALE_RST;
      expected_q.delete();
      pending = 0;
    end else begin
      // results leave before a new item enters
      if (done_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: result with no pose pending, expected nothing got dx %0d",
                     $time, result_i.dx_steps);
        end else begin
          want = expected_q.pop_front();
          checked++;
          check_field("dx_steps", want.dx_steps, result_i.dx_steps);
          check_field("dy_steps", want.dy_steps, result_i.dy_steps);
          check_field("dz_steps", want.dz_steps, result_i.dz_steps);
          check_field("dtilt_steps", want.dtilt_steps, result_i.dtilt_steps);
          check_field("dspin_steps", want.dspin_steps, result_i.dspin_steps);
          check_field("saturated", want.saturated, result_i.saturated);
        end
      end
      if (start_i && !busy_i) begin
        want = predict_delta(item_i);
        if (want.saturated) clipped++;
        expected_q.push_back(want);
      end
      pending = expected_q.size();
      // register port access phase
      if (psel_i && penable_i && pready_i) begin
        idx = paddr_i[pstd_pkg::ADDR_W-1:2];
        if (pwrite_i) begin
          case (idx)
            pstd_pkg::REG_TOOL_TIP:   regs.tool_tip   = pwdata_i;
            pstd_pkg::REG_SCALE_X:    regs.scale_x    = pwdata_i;
            pstd_pkg::REG_SCALE_Y:    regs.scale_y    = pwdata_i;
            pstd_pkg::REG_SCALE_Z:    regs.scale_z    = pwdata_i;
            pstd_pkg::REG_SCALE_TILT: regs.scale_tilt = pwdata_i;
            pstd_pkg::REG_SCALE_SPIN: regs.scale_spin = pwdata_i;
            default: ;
          endcase
        end else if (register_value(idx, reg_val) && prdata_i !== reg_val) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: register %0d read expected %h got %h", $time, idx, reg_val,
                     prdata_i);
        end
      end
    end
  end

endmodule

@@ verif/pose_to_step_delta_core_test.sv @@
// pose_to_step_delta_core_test: drives poses and register settings into the core
// and reports the verdict; depends on pstd_pkg and pose_to_step_delta_checker
module pose_to_step_delta_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SINE_TABLE_ENTRIES = 1024;
  localparam int unsigned FRAC_BITS          = 16;
  localparam int unsigned PHASES             = 7;
  localparam int unsigned PHASE_ITEMS        = 200;
  localparam int unsigned CYCLE_LIMIT        = 400000;
  localparam int unsigned SETTLE_CYCLES      = 12;

  // register slots past the map; writes there must change nothing
  localparam logic [pstd_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [pstd_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;
  localparam logic [31:0] U32_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] ONE_MM    = 32'h0001_0000;
  localparam logic [23:0] QUARTER   = 24'h00_4000;
  localparam logic [23:0] HALF      = 24'h00_8000;
  localparam logic [23:0] THREE_Q   = 24'h00_C000;
  localparam logic [23:0] ANG_MAX   = 24'h7F_FFFF;
  localparam logic [23:0] ANG_MIN   = 24'h80_0000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  pstd_pkg::in_t                 in_i;
  logic                          done_o;
  pstd_pkg::out_t                result_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pstd_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned clipped;
  int unsigned settings = 1;
  int unsigned cycle_count = 0;

  always #5 clk_i = ~clk_i;

  pose_to_step_delta_core #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
    .FRAC_BITS         (FRAC_BITS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .done_o  (done_o),
    .result_o(result_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pose_to_step_delta_checker #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
    .FRAC_BITS         (FRAC_BITS)
  ) i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_i   (busy),
    .item_i   (in_i),
    .done_i   (done_o),
    .result_i (result_o),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_i (prdata),
    .pready_i (pready),
    .errors_o (errors),
    .pending_o(pending),
    .checked_o(checked),
    .clipped_o(clipped)
  );

  // random field values, biased toward extremes and small magnitudes
  function automatic logic [31:0] pick_length();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2, 3: v = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      4: begin
        case ($urandom_range(0, 3))
          0: v = S32_MAX;
          1: v = S32_MIN;
          2: v = '0;
          default: v = U32_MAX;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [23:0] pick_angle();
    logic [23:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = 24'($urandom);
      // near the point where the phase rounds up to a full turn
      3: v = {8'($urandom), 16'(16'hFFC0 + $urandom_range(0, 63))};
      // close to a quadrant boundary
      4: v = {8'($urandom), 2'($urandom), 14'($urandom_range(0, 40))};
      default: v = 24'($urandom_range(0, 2 * 32'h10000)) - 24'h01_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_steps();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0, 1, 2: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      3: v = $urandom;
      default: v = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_scale();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1, 2: v = $urandom_range(32'h0000_1000, 32'h0100_0000);
      default: begin
        case ($urandom_range(0, 2))
          0: v = '0;
          1: v = U32_MAX;
          default: v = pstd_pkg::SCALE_RST;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic pstd_pkg::in_t random_pose();
    pstd_pkg::in_t p;
    p.x_mm           = pick_length();
    p.y_mm           = pick_length();
    p.z_mm           = pick_length();
    p.tilt_turns     = pick_angle();
    p.spin_turns     = pick_angle();
    p.cur_x_steps    = pick_steps();
    p.cur_y_steps    = pick_steps();
    p.cur_z_steps    = pick_steps();
    p.cur_tilt_steps = pick_steps();
    p.cur_spin_steps = pick_steps();
    return p;
  endfunction

  function automatic pstd_pkg::in_t make_pose(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [23:0] tilt,
                                              input logic [23:0] spin,
                                              input logic [31:0] cur);
    pstd_pkg::in_t p;
    p.x_mm           = x;
    p.y_mm           = y;
    p.z_mm           = z;
    p.tilt_turns     = tilt;
    p.spin_turns     = spin;
    p.cur_x_steps    = cur;
    p.cur_y_steps    = cur;
    p.cur_z_steps    = cur;
    p.cur_tilt_steps = cur;
    p.cur_spin_steps = cur;
    return p;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // all tasks below start and end on a falling edge with nothing driven yet there

  // present one pose and hold it until the core takes it
  task automatic send_pose(input pstd_pkg::in_t v, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      in_i  <= random_pose();
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= v;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // stop sending and let every pending result come out
  task automatic drain_results();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [pstd_pkg::IDX_W-1:0] idx,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic read_all_regs();
    reg_access(1'b0, pstd_pkg::REG_TOOL_TIP, '0);
    reg_access(1'b0, pstd_pkg::REG_SCALE_X, '0);
    reg_access(1'b0, pstd_pkg::REG_SCALE_Y, '0);
    reg_access(1'b0, pstd_pkg::REG_SCALE_Z, '0);
    reg_access(1'b0, pstd_pkg::REG_SCALE_TILT, '0);
    reg_access(1'b0, pstd_pkg::REG_SCALE_SPIN, '0);
  endtask

  task automatic write_config(input logic [31:0] tip, input logic [31:0] sx,
                              input logic [31:0] sy, input logic [31:0] sz,
                              input logic [31:0] st, input logic [31:0] ss);
    reg_access(1'b1, pstd_pkg::REG_TOOL_TIP, tip);
    reg_access(1'b1, pstd_pkg::REG_SCALE_X, sx);
    reg_access(1'b1, pstd_pkg::REG_SCALE_Y, sy);
    reg_access(1'b1, pstd_pkg::REG_SCALE_Z, sz);
    reg_access(1'b1, pstd_pkg::REG_SCALE_TILT, st);
    reg_access(1'b1, pstd_pkg::REG_SCALE_SPIN, ss);
    read_all_regs();
    settings++;
  endtask

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    bit burst;
    rst_ni  = 1'b0;
    start   = 1'b0;
    in_i    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    burst   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values, then directed poses at unit scale
    read_all_regs();
    send_pose(make_pose('0, '0, '0, '0, '0, '0), 0);
    send_pose(make_pose(S32_MAX, S32_MAX, S32_MAX, '0, '0, '0), 0);
    send_pose(make_pose(S32_MIN, S32_MIN, S32_MIN, '0, '0, '0), 1);
    send_pose(make_pose(ONE_MM, 2 * ONE_MM, 3 * ONE_MM, '0, QUARTER, '0), 0);
    send_pose(make_pose(ONE_MM, 2 * ONE_MM, 3 * ONE_MM, QUARTER, HALF, 32'd5), 0);
    send_pose(make_pose(ONE_MM, 2 * ONE_MM, 3 * ONE_MM, HALF, THREE_Q, -32'd5), 2);
    // negative angles wrap within the turn
    send_pose(make_pose(-(3 * ONE_MM / 2), 4 * ONE_MM, -2 * ONE_MM, -QUARTER, -QUARTER, '0), 0);
    send_pose(make_pose(S32_MAX, S32_MIN, 32'd7, ANG_MAX, ANG_MIN, '0), 0);
    // phase rounds up to a full turn and wraps to table step zero
    send_pose(make_pose(ONE_MM, ONE_MM, ONE_MM, 24'h00_FFF0, 24'h01_FFE0, '0), 0);
    // deltas clipped below and above
    send_pose(make_pose('0, S32_MIN, '0, '0, '0, S32_MAX), 3);
    send_pose(make_pose(S32_MAX, '0, S32_MIN, '0, '0, S32_MIN), 0);
    drain_results();

    // largest scales and tip: step targets clip
    write_config(S32_MAX, U32_MAX, U32_MAX, U32_MAX, U32_MAX, U32_MAX);
    send_pose(make_pose('0, '0, '0, '0, '0, '0), 0);
    send_pose(make_pose(32'd1, '0, '0, QUARTER, '0, '0), 0);
    send_pose(make_pose(S32_MIN, S32_MAX, S32_MAX, HALF, ANG_MAX, '0), 1);
    send_pose(make_pose(U32_MAX, U32_MAX, U32_MAX, 24'hFF_FFFF, 24'hFF_FFFF, U32_MAX), 0);
    drain_results();

    // zero scales and most negative tip: deltas are the negated counts
    write_config(S32_MIN, '0, '0, '0, '0, '0);
    send_pose(make_pose(S32_MAX, S32_MAX, S32_MAX, ANG_MAX, ANG_MAX, S32_MIN), 0);
    send_pose(make_pose(32'd1, 32'd2, 32'd3, 24'd4, 24'd5, 32'd12345), 0);
    drain_results();

    // random poses over a series of register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_config(pstd_pkg::TOOL_TIP_RST, pstd_pkg::SCALE_RST, pstd_pkg::SCALE_RST,
                        pstd_pkg::SCALE_RST, pstd_pkg::SCALE_RST, pstd_pkg::SCALE_RST);
        1: write_config(S32_MAX, U32_MAX, U32_MAX, U32_MAX, U32_MAX, U32_MAX);
        2: write_config(S32_MIN, '0, '0, '0, '0, '0);
        default: begin
          if (ph == 3) begin
            reg_access(1'b1, REG_SPARE_LO, $urandom);
            reg_access(1'b1, REG_SPARE_HI, $urandom);
          end
          write_config(pick_length(), pick_scale(), pick_scale(), pick_scale(),
                       pick_scale(), pick_scale());
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) burst = ($urandom_range(0, 9) < 3);
        // hold off once per setting until the pipeline is empty
        if (n == PHASE_ITEMS / 2) drain_results();
        send_pose(random_pose(), burst ? 0 : pick_gap());
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("summary: %0d results checked over %0d register settings, %0d of them clipped",
             checked, settings, clipped);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
